FILE: sv/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the json string unescape core: channel
// words, decoder modes and the queue entry passed from front to back.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // decoder modes
  typedef enum logic [2:0] {
    MODE_IDLE = 3'd0,
    MODE_TEXT = 3'd1,
    MODE_ESC  = 3'd2,
    MODE_HEX  = 3'd3,
    MODE_CONT = 3'd4
  } mode_t;

  // result kinds
  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_END   = 2'd1,
    KIND_ERROR = 2'd2
  } kind_t;

  // error codes
  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_ESCAPE = 2'd1,
    ERR_HEX    = 2'd2,
    ERR_BYTE   = 2'd3
  } err_t;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       first;
  } in_word_t;

  // output word
  typedef struct packed {
    logic [7:0] out_byte;
    kind_t      kind;
    err_t       error_code;
    logic       last;
  } out_word_t;

  // classified input byte: one to three results of the same kind
  typedef struct packed {
    logic [1:0] count;
    kind_t      kind;
    err_t       err;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } jsu_entry_t;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

endpackage

FILE: sv/json_string_unescape_core.sv
// ----------------------------------------------------------------------------
// json_string_unescape_core
// Decodes a json string body one byte per word, expanding escapes and
// checking utf-8, and emits decoded bytes, end and error words.
// ----------------------------------------------------------------------------
// Usage:
//   byte channel (byte_valid/byte_ready/byte_item) takes one body byte per
//   word; set first on the byte after the opening quote. Bytes seen with no
//   string open are dropped without a result.
//   res channel (res_valid/res_ready/res_item) gives decoded bytes, an end
//   word at the closing quote, or an error word after which the string is
//   to be discarded. last marks the final result caused by one input byte.
// Throughput: one byte word per cycle while the queue is not full. A \u
//   escape that ends in a 2 or 3 byte utf-8 sequence gives 2 or 3 results,
//   which the result serializer sends one per cycle unless res_ready stalls;
//   the 4-entry queue between decoder and serializer absorbs short bursts.
// Path: a taken byte's entry is written into the queue, then its results
//   are loaded from the queue head into the registered output.
// Stall: when res_ready is low the output register holds its word, the
//   queue fills, and byte_ready drops once it holds 4 entries.
// Reset: synchronous; clears decoder state, queue and output valid.
// ----------------------------------------------------------------------------
module json_string_unescape_core
  import jsu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_word_t  byte_item,
  output logic      res_valid,
  input  logic      res_ready,
  output out_word_t res_item
);

  logic       q_full;
  logic       q_push;
  jsu_entry_t q_entry;
  logic       q_pop;
  logic       head_valid;
  jsu_entry_t head_entry;

  // decoder front end
  jsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_entry    (q_entry)
  );

  // entry queue
  jsu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (head_valid),
    .head_entry (head_entry)
  );

  // result serializer
  jsu_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_entry (head_entry),
    .pop        (q_pop),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

endmodule

FILE: sv/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Byte decoder: tracks escape, hex and utf-8 continuation state and turns
// each input byte into at most one queue entry of one to three results.
// ----------------------------------------------------------------------------
module jsu_front
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  in_word_t   byte_item,
  input  logic       q_full,
  output logic       q_push,
  output jsu_entry_t q_entry
);

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash  = 8'h2F;
  localparam logic [7:0] ChU      = 8'h75;

  mode_t       mode;
  mode_t       mode_next;
  logic [1:0]  hex_count;
  logic [1:0]  hex_count_next;
  logic [15:0] code_accum;
  logic [15:0] code_accum_next;
  logic [1:0]  cont_left;
  logic [1:0]  cont_left_next;

  logic        accept;
  mode_t       cur_mode;
  logic [1:0]  cur_hex_count;
  logic [15:0] cur_accum;
  logic [1:0]  cur_cont;
  logic [7:0]  b;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic        esc_ok;
  logic [7:0]  esc_val;
  logic [1:0]  lead_cont;
  logic        lead_ok;
  logic [15:0] accum_shift;
  logic [1:0]  cont_dec;

  assign byte_ready = !q_full;
  assign accept     = byte_valid && byte_ready;
  assign b          = byte_item.in_byte;

  // a first byte restarts the decoder in text mode
  always_comb begin
    if (byte_item.first) begin
      cur_mode      = MODE_TEXT;
      cur_hex_count = 2'd0;
      cur_accum     = 16'd0;
      cur_cont      = 2'd0;
    end else begin
      cur_mode      = mode;
      cur_hex_count = hex_count;
      cur_accum     = code_accum;
      cur_cont      = cont_left;
    end
  end

  // byte classification
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    case (b) inside
      [8'h30:8'h39]: hex_val = b[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: hex_val = b[3:0] + 4'd9;
      default:       hex_ok  = 1'b0;
    endcase

    esc_ok  = 1'b1;
    esc_val = b;
    case (b)
      ChQuote, ChBslash, ChSlash: esc_val = b;
      8'h62:   esc_val = 8'h08;
      8'h66:   esc_val = 8'h0C;
      8'h6E:   esc_val = 8'h0A;
      8'h72:   esc_val = 8'h0D;
      8'h74:   esc_val = 8'h09;
      default: esc_ok  = 1'b0;
    endcase

    lead_ok   = 1'b1;
    lead_cont = 2'd0;
    if (b[7:5] == 3'b110)        lead_cont = 2'd1;
    else if (b[7:4] == 4'b1110)  lead_cont = 2'd2;
    else if (b[7:3] == 5'b11110) lead_cont = 2'd3;
    else                         lead_ok   = 1'b0;

    accum_shift = {cur_accum[11:0], hex_val};
    cont_dec    = (cur_cont != 2'd0) ? cur_cont - 2'd1 : 2'd0;
  end

  // next state
  always_comb begin
    mode_next = mode;
    if (accept) begin
      unique case (cur_mode)
        MODE_TEXT: begin
          if (b == ChQuote)       mode_next = MODE_IDLE;
          else if (b == ChBslash) mode_next = MODE_ESC;
          else if (b < 8'h20)     mode_next = MODE_IDLE;
          else if (!b[7])         mode_next = MODE_TEXT;
          else if (lead_ok)       mode_next = MODE_CONT;
          else                    mode_next = MODE_IDLE;
        end
        MODE_ESC: begin
          if (b == ChU)           mode_next = MODE_HEX;
          else if (esc_ok)        mode_next = MODE_TEXT;
          else                    mode_next = MODE_IDLE;
        end
        MODE_HEX: begin
          if (!hex_ok)                     mode_next = MODE_IDLE;
          else if (cur_hex_count == 2'd3)  mode_next = MODE_TEXT;
          else                             mode_next = MODE_HEX;
        end
        MODE_CONT: begin
          if (b[7:6] != 2'b10)       mode_next = MODE_IDLE;
          else if (cont_dec == 2'd0) mode_next = MODE_TEXT;
          else                       mode_next = MODE_CONT;
        end
        default: mode_next = MODE_IDLE;
      endcase
    end
  end

  // outputs: counters and the queue entry
  always_comb begin
    hex_count_next  = hex_count;
    code_accum_next = code_accum;
    cont_left_next  = cont_left;
    q_entry         = '{count: 2'd0, kind: KIND_DATA, err: ERR_NONE,
                        b0: 8'd0, b1: 8'd0, b2: 8'd0};
    if (accept) begin
      hex_count_next  = cur_hex_count;
      code_accum_next = cur_accum;
      cont_left_next  = cur_cont;
      unique case (cur_mode)
        MODE_TEXT: begin
          if (b == ChQuote) begin
            q_entry.count = 2'd1;
            q_entry.kind  = KIND_END;
          end else if (b == ChBslash) begin
            q_entry.count = 2'd0;
          end else if (b < 8'h20 || (b[7] && !lead_ok)) begin
            q_entry.count = 2'd1;
            q_entry.kind  = KIND_ERROR;
            q_entry.err   = ERR_BYTE;
          end else begin
            q_entry.count = 2'd1;
            q_entry.b0    = b;
            if (b[7]) cont_left_next = lead_cont;
          end
        end
        MODE_ESC: begin
          if (b == ChU) begin
            hex_count_next  = 2'd0;
            code_accum_next = 16'd0;
          end else if (esc_ok) begin
            q_entry.count = 2'd1;
            q_entry.b0    = esc_val;
          end else begin
            q_entry.count = 2'd1;
            q_entry.kind  = KIND_ERROR;
            q_entry.err   = ERR_ESCAPE;
          end
        end
        MODE_HEX: begin
          if (!hex_ok) begin
            q_entry.count = 2'd1;
            q_entry.kind  = KIND_ERROR;
            q_entry.err   = ERR_HEX;
          end else begin
            code_accum_next = accum_shift;
            if (cur_hex_count != 2'd3) begin
              hex_count_next = cur_hex_count + 2'd1;
            end else begin
              hex_count_next = 2'd0;
              // shortest utf-8 form of the code point
              if (accum_shift[15:7] == 9'd0) begin
                q_entry.count = 2'd1;
                q_entry.b0    = accum_shift[7:0];
              end else if (accum_shift[15:11] == 5'd0) begin
                q_entry.count = 2'd2;
                q_entry.b0    = {3'b110, accum_shift[10:6]};
                q_entry.b1    = {2'b10, accum_shift[5:0]};
              end else begin
                q_entry.count = 2'd3;
                q_entry.b0    = {4'b1110, accum_shift[15:12]};
                q_entry.b1    = {2'b10, accum_shift[11:6]};
                q_entry.b2    = {2'b10, accum_shift[5:0]};
              end
            end
          end
        end
        MODE_CONT: begin
          q_entry.count = 2'd1;
          if (b[7:6] != 2'b10) begin
            q_entry.kind = KIND_ERROR;
            q_entry.err  = ERR_BYTE;
          end else begin
            q_entry.b0     = b;
            cont_left_next = cont_dec;
          end
        end
        default: q_entry.count = 2'd0;
      endcase
    end
  end

  assign q_push = accept && (q_entry.count != 2'd0);

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      hex_count  <= 2'd0;
      code_accum <= 16'd0;
      cont_left  <= 2'd0;
    end else begin
      mode       <= mode_next;
      hex_count  <= hex_count_next;
      code_accum <= code_accum_next;
      cont_left  <= cont_left_next;
    end
  end

endmodule

FILE: sv/jsu_queue.sv
// ----------------------------------------------------------------------------
// jsu_queue
// Small first-in first-out queue of decoded entries between the decoder
// and the result serializer.
// ----------------------------------------------------------------------------
module jsu_queue
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  jsu_entry_t push_entry,
  output logic       full,
  input  logic       pop,
  output logic       head_valid,
  output jsu_entry_t head_entry
);

  jsu_entry_t           slots [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr;
  logic [QueuePtrW-1:0] rd_ptr;
  logic [QueuePtrW:0]   fill;

  assign full       = (fill == (QueuePtrW+1)'(QueueDepth));
  assign head_valid = (fill != '0);
  assign head_entry = slots[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QueuePtrW'(1);
      if (pop)  rd_ptr <= rd_ptr + QueuePtrW'(1);
      case ({push, pop})
        2'b10:   fill <= fill + (QueuePtrW+1)'(1);
        2'b01:   fill <= fill - (QueuePtrW+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: sv/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Result serializer: walks the results of the head entry into the output
// register, one per cycle unless stalled, and marks the last of each entry.
// ----------------------------------------------------------------------------
module jsu_back
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  jsu_entry_t head_entry,
  output logic       pop,
  output logic       res_valid,
  input  logic       res_ready,
  output out_word_t  res_item
);

  logic [1:0] idx;
  logic       load;
  logic       is_last;
  logic [7:0] sel_byte;

  assign load    = head_valid && (!res_valid || res_ready);
  assign is_last = (idx == head_entry.count - 2'd1);
  assign pop     = load && is_last;

  // pick the byte of the current result
  always_comb begin
    case (idx)
      2'd0:    sel_byte = head_entry.b0;
      2'd1:    sel_byte = head_entry.b1;
      default: sel_byte = head_entry.b2;
    endcase
  end

  // result index within the head entry
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (load) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_item.out_byte   <= sel_byte;
      res_item.kind       <= head_entry.kind;
      res_item.error_code <= head_entry.err;
      res_item.last       <= is_last;
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the json string unescape core. A software decoder
// predicts every result word from the accepted byte words; a monitor
// compares each result word field by field against the oldest prediction.
// Directed strings hit the error paths, restarts and utf-8 forms; random
// strings, mostly well formed, cover escapes, \u code points and raw utf-8.
// ----------------------------------------------------------------------------
module testbench;
  import jsu_pkg::*;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam int         HOLD_CYCLES = 80;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_word_t  byte_item = '0;
  logic      res_valid;
  logic      res_ready = 1'b0;
  out_word_t res_item;

  // decoder copy used for prediction
  mode_t       dec_mode = MODE_IDLE;
  logic [1:0]  dec_hex_cnt = '0;
  logic [15:0] dec_code = '0;
  logic [1:0]  dec_cont_left = '0;
  out_word_t   pending_results[$];

  int  mismatches = 0;
  int  bytes_fed = 0;
  bit  next_first = 1'b0;
  bit  src_calm = 1'b0;
  bit  sink_calm = 1'b0;
  int  hold_requests = 0;
  int  hold_seen = 0;
  int  hold_left = 0;

  json_string_unescape_core dut (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_item  (byte_item),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res_item   (res_item)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic void add_result(input logic [7:0] b, input kind_t k, input err_t e);
    out_word_t w;
    w.out_byte   = b;
    w.kind       = k;
    w.error_code = e;
    w.last       = 1'b0;
    pending_results.push_back(w);
  endfunction

  // predict the result words of one accepted byte word
  function automatic void decode_byte(input in_word_t w);
    logic [7:0] b;
    int         base;
    int         hv;
    out_word_t  tail;
    b    = w.in_byte;
    base = pending_results.size();
    if (w.first) begin
      dec_mode      = MODE_TEXT;
      dec_hex_cnt   = '0;
      dec_code      = '0;
      dec_cont_left = '0;
    end
    case (dec_mode)
      MODE_TEXT: begin
        if (b == CH_QUOTE) begin
          dec_mode = MODE_IDLE;
          add_result(8'h00, KIND_END, ERR_NONE);
        end else if (b == CH_BSLASH) begin
          dec_mode = MODE_ESC;
        end else if (b < 8'h20) begin
          dec_mode = MODE_IDLE;
          add_result(8'h00, KIND_ERROR, ERR_BYTE);
        end else if (!b[7]) begin
          add_result(b, KIND_DATA, ERR_NONE);
        end else begin
          // utf-8 lead byte sets how many continuation bytes follow
          if (b[7:5] == 3'b110) dec_cont_left = 2'd1;
          else if (b[7:4] == 4'hE) dec_cont_left = 2'd2;
          else if (b[7:3] == 5'h1E) dec_cont_left = 2'd3;
          else dec_cont_left = 2'd0;
          if (dec_cont_left == 2'd0) begin
            dec_mode = MODE_IDLE;
            add_result(8'h00, KIND_ERROR, ERR_BYTE);
          end else begin
            dec_mode = MODE_CONT;
            add_result(b, KIND_DATA, ERR_NONE);
          end
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_TEXT;
        case (b)
          CH_U: begin
            dec_mode    = MODE_HEX;
            dec_hex_cnt = '0;
            dec_code    = '0;
          end
          CH_QUOTE, CH_BSLASH, "/": add_result(b, KIND_DATA, ERR_NONE);
          "b": add_result(8'h08, KIND_DATA, ERR_NONE);
          "f": add_result(8'h0C, KIND_DATA, ERR_NONE);
          "n": add_result(8'h0A, KIND_DATA, ERR_NONE);
          "r": add_result(8'h0D, KIND_DATA, ERR_NONE);
          "t": add_result(8'h09, KIND_DATA, ERR_NONE);
          default: begin
            dec_mode = MODE_IDLE;
            add_result(8'h00, KIND_ERROR, ERR_ESCAPE);
          end
        endcase
      end
      MODE_HEX: begin
        hv = -1;
        if (b >= "0" && b <= "9") hv = b - "0";
        else if (b >= "A" && b <= "F") hv = b - "A" + 10;
        else if (b >= "a" && b <= "f") hv = b - "a" + 10;
        if (hv < 0) begin
          dec_mode = MODE_IDLE;
          add_result(8'h00, KIND_ERROR, ERR_HEX);
        end else begin
          dec_code = {dec_code[11:0], hv[3:0]};
          if (dec_hex_cnt < 2'd3) begin
            dec_hex_cnt = dec_hex_cnt + 2'd1;
          end else begin
            // shortest utf-8 form of the code point
            dec_hex_cnt = '0;
            dec_mode    = MODE_TEXT;
            if (dec_code < 16'h0080) begin
              add_result(dec_code[7:0], KIND_DATA, ERR_NONE);
            end else if (dec_code < 16'h0800) begin
              add_result({3'b110, dec_code[10:6]}, KIND_DATA, ERR_NONE);
              add_result({2'b10, dec_code[5:0]}, KIND_DATA, ERR_NONE);
            end else begin
              add_result({4'hE, dec_code[15:12]}, KIND_DATA, ERR_NONE);
              add_result({2'b10, dec_code[11:6]}, KIND_DATA, ERR_NONE);
              add_result({2'b10, dec_code[5:0]}, KIND_DATA, ERR_NONE);
            end
          end
        end
      end
      MODE_CONT: begin
        if (b[7:6] != 2'b10) begin
          dec_mode = MODE_IDLE;
          add_result(8'h00, KIND_ERROR, ERR_BYTE);
        end else begin
          if (dec_cont_left > 2'd0) dec_cont_left = dec_cont_left - 2'd1;
          if (dec_cont_left == 2'd0) dec_mode = MODE_TEXT;
          add_result(b, KIND_DATA, ERR_NONE);
        end
      end
      default: dec_mode = MODE_IDLE;
    endcase
    // mark the final word caused by this byte
    if (pending_results.size() > base) begin
      tail      = pending_results.pop_back();
      tail.last = 1'b1;
      pending_results.push_back(tail);
    end
  endfunction

  // result monitor
  always @(posedge clk) begin
    out_word_t got;
    out_word_t want;
    if (!rst && res_valid && res_ready) begin
      got = res_item;
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result word %h with nothing pending", got));
      end else begin
        want = pending_results.pop_front();
        if (got.out_byte !== want.out_byte)
          report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
        if (got.kind !== want.kind)
          report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
        if (got.error_code !== want.error_code)
          report_mismatch($sformatf("error_code %0d, expected %0d",
                                    got.error_code, want.error_code));
        if (got.last !== want.last)
          report_mismatch($sformatf("last %b, expected %b", got.last, want.last));
      end
    end
  end

  // result receiver: random stalls, calm stretches and long hold-offs
  always @(negedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_ready <= 1'b0;
    end else begin
      res_ready <= sink_calm || ($urandom_range(99) >= 35);
    end
  end

  // drive one byte word and wait for the handshake; called at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic f);
    if (!src_calm && $urandom_range(99) < 35) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    byte_valid        <= 1'b1;
    byte_item.in_byte <= b;
    byte_item.first   <= f;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    decode_byte(byte_item);
    @(negedge clk);
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_byte(b, next_first);
    next_first = 1'b0;
    bytes_fed++;
  endtask

  task automatic wait_results_drained;
    int guard;
    guard = 0;
    byte_valid <= 1'b0;
    while (pending_results.size() != 0 && guard < 5000) begin
      @(negedge clk);
      guard++;
    end
    if (pending_results.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_results.size()));
    repeat (4) @(negedge clk);
  endtask

  // \uXXXX escape; cls picks a 1, 2 or 3 byte code point
  task automatic put_unicode(input int cls);
    logic [15:0] cp;
    logic [3:0]  nib;
    int          i;
    case (cls)
      0: cp = 16'($urandom_range(16'h007F));
      1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
      default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
    endcase
    put_byte(CH_BSLASH);
    put_byte(CH_U);
    for (i = 3; i >= 0; i--) begin
      nib = cp[i*4 +: 4];
      if (nib < 4'd10) put_byte(8'h30 + nib);
      else put_byte(($urandom_range(1) ? 8'h61 : 8'h41) + nib - 8'd10);
    end
  endtask

  // one piece of string content; noisy pieces may be any byte at all
  task automatic put_element(input bit noisy);
    logic [7:0] b;
    logic [7:0] esc_letters[8];
    int         sel;
    int         len;
    int         i;
    esc_letters = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};
    sel = $urandom_range(9);
    if (noisy && sel == 0) begin
      put_byte(8'($urandom_range(255)));
    end else if (sel <= 3) begin
      b = CH_QUOTE;
      while (b == CH_QUOTE || b == CH_BSLASH) b = 8'($urandom_range(8'h7F, 8'h20));
      put_byte(b);
    end else if (sel <= 5) begin
      put_byte(CH_BSLASH);
      put_byte(esc_letters[$urandom_range(7)]);
    end else if (sel <= 7) begin
      put_unicode($urandom_range(2));
    end else begin
      // raw utf-8 sequence of 2 to 4 bytes
      len = $urandom_range(4, 2);
      b = 8'($urandom_range(255));
      case (len)
        2: put_byte({3'b110, b[4:0]});
        3: put_byte({4'hE, b[3:0]});
        default: put_byte({5'h1E, b[2:0]});
      endcase
      for (i = 1; i < len; i++) begin
        b = 8'($urandom_range(255));
        put_byte({2'b10, b[5:0]});
      end
    end
  endtask

  task automatic put_random_string(input bit noisy);
    int n;
    int i;
    next_first = 1'b1;
    n = $urandom_range(5, 1);
    for (i = 0; i < n; i++) put_element(noisy);
    if (!noisy || $urandom_range(3) != 0) put_byte(CH_QUOTE);
    // stray bytes with first low, usually between strings
    if ($urandom_range(4) == 0) send_byte(8'($urandom_range(255)), 1'b0);
  endtask

  task automatic reset_dut;
    rst = 1'b1;
    dec_mode      = MODE_IDLE;
    dec_hex_cnt   = '0;
    dec_code      = '0;
    dec_cont_left = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
  endtask

  task automatic test_special_cases;
    // byte with no string open is dropped
    send_byte(8'hFF, 1'b0);
    // control byte
    next_first = 1'b1; put_byte(8'h00);
    // bad lead bytes at both ends
    next_first = 1'b1; put_byte(8'hFF);
    next_first = 1'b1; put_byte(8'h80);
    // quote where a continuation is due
    next_first = 1'b1; put_byte(8'hE2); put_byte(CH_QUOTE);
    // restart in the middle of an escape
    next_first = 1'b1; put_byte(CH_BSLASH);
    next_first = 1'b1; put_byte(CH_QUOTE);
    // bad escape letter
    next_first = 1'b1; put_byte(CH_BSLASH); put_byte("x");
    // bad hex digit
    next_first = 1'b1; put_byte(CH_BSLASH); put_byte(CH_U); put_byte("0"); put_byte("g");
    // largest code point, mixed case digits
    next_first = 1'b1; put_byte(CH_BSLASH); put_byte(CH_U);
    put_byte("F"); put_byte("f"); put_byte("F"); put_byte("f"); put_byte(CH_QUOTE);
    // 4-byte utf-8 sequence
    next_first = 1'b1; put_byte(8'hF4); put_byte(8'h8F); put_byte(8'hBF); put_byte(8'hBF);
    put_byte(CH_QUOTE);
    wait_results_drained();
  endtask

  task automatic test_streaming;
    src_calm  = 1'b1;
    sink_calm = 1'b1;
    repeat (6) put_random_string(1'b0);
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  task automatic test_backpressure;
    // receiver holds off while 3-byte \u escapes keep coming
    hold_requests++;
    src_calm   = 1'b1;
    next_first = 1'b1;
    repeat (8) put_unicode(2);
    put_byte(CH_QUOTE);
    src_calm = 1'b0;
    wait_results_drained();
  endtask

  task automatic test_random_strings;
    while (bytes_fed < 320) put_random_string($urandom_range(4) == 0);
  endtask

  initial begin
    reset_dut();
    test_special_cases();
    test_streaming();
    test_backpressure();
    test_random_strings();
    wait_results_drained();
    repeat (10) @(negedge clk);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // run time limit
  initial begin
    #(2_000_000);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
